@@ sv/gmd_pkg.sv @@
package gmd_pkg;

	// Grid geometry. The field widths of the stream items are fixed.
	localparam int SIDE    = 32;
	localparam int TILES   = SIDE * SIDE;
	localparam int COORD_W = (SIDE > 1) ? $clog2(SIDE) : 1;
	localparam int ADDR_W  = $clog2(TILES);
	localparam int DEPTH_W = $clog2(TILES + 1);
	localparam int STK_W   = 2 * COORD_W;

	localparam int TILE_W  = 10;
	localparam int WALL_W  = 12;
	localparam int RND_W   = 8;
	localparam int RES_W   = TILE_W + 1 + WALL_W + 1 + 1;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

	// Index of the first vertical wall.
	localparam int VWALL_BASE = SIDE * (SIDE + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_POP,
		ST_FIN
	} state_t;

	// Neighbour order used when listing candidates.
	typedef enum logic [1:0] {
		DIR_DOWN  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	localparam logic [0:0] CMD_STEP    = 1'b0;
	localparam logic [0:0] CMD_RESTART = 1'b1;

	typedef struct packed {
		logic              done_res;
		logic              backtracked;
		logic [WALL_W-1:0] wall_index;
		logic              carved;
		logic [TILE_W-1:0] tile_now;
	} result_t;

	// Row-major tile index of a grid position.
	function automatic logic [ADDR_W-1:0] tile_of(input logic [COORD_W-1:0] row,
			input logic [COORD_W-1:0] col);
		tile_of = ADDR_W'(int'(row) * SIDE + int'(col));
	endfunction

	// Left wall of the tile at a grid position.
	function automatic logic [WALL_W-1:0] vwall_of(input logic [COORD_W-1:0] row,
			input logic [COORD_W-1:0] col);
		vwall_of = WALL_W'(VWALL_BASE + int'(row) * (SIDE + 1) + int'(col));
	endfunction

	// Remainder by three through the base-four digit sum.
	function automatic logic [1:0] mod3(input logic [RND_W-1:0] x);
		logic [3:0] s;
		logic [2:0] t;
		s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		mod3 = t[1:0];
	endfunction

endpackage

@@ sv/gmd_ram.sv @@
module gmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/grid_maze_dfs_step_unit.sv @@
// Depth-first maze carver for a square grid of gmd_pkg::SIDE tiles a side. Each request on the
// slave stream is either a step (tuser 0) or a restart (tuser 1), and each produces exactly one
// result on the master stream. A step looks at the four neighbours of the current tile one at a
// time through the single read port of the visited-map RAM, then carves into the neighbour
// picked by random_value modulo the number of unvisited neighbours, or pops the path stack, or
// raises done once the stack is empty. A backtracking step passes through an extra state,
// ST_POP, for the stack RAM read, and a step after done goes straight to the result. The four
// sequential visited-map reads, one per cycle, and the registered RAM output set the step time.
// A restart, and likewise the release of reset, sweeps the whole visited map one tile per
// cycle, during which no request is taken; the restart result follows the sweep, while the
// sweep after reset produces no result. The block holds one request at a time, but the result
// register lets it take the next request while the previous result is still waiting.
module grid_maze_dfs_step_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// random_value [7:0]
	input  logic [gmd_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// command [0]
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tile_now [9:0], carved [10], wall_index [22:11], backtracked [23], done_res [24], zeros above
	output logic [gmd_pkg::M_DATA_W-1:0]  m_axis_tdata
);

	import gmd_pkg::*;

	// Sequencer and architectural state.
	state_t               state_q, state_d;
	logic [ADDR_W-1:0]    clr_q;
	logic                 restart_pend_q;
	logic [COORD_W-1:0]   row_q, col_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic                 done_q;

	// Per-request working registers.
	logic [RND_W-1:0]     rnd_q;
	logic [2:0]           k_q;
	logic [3:0]           cand_q;
	logic                 res_carved_q;
	logic [WALL_W-1:0]    res_wall_q;
	logic                 res_back_q;

	// Visited-map read pipeline.
	logic                 scan_pend_s1;
	logic [1:0]           dir_s1;
	logic                 exist_s1;

	// Result register.
	result_t              out_q;
	logic                 out_valid_q;

	// Memory ports.
	logic                 vis_we;
	logic [ADDR_W-1:0]    vis_waddr;
	logic                 vis_wdata;
	logic [ADDR_W-1:0]    vis_raddr;
	logic                 vis_rdata;
	logic                 stk_we;
	logic [ADDR_W-1:0]    stk_raddr;
	logic [STK_W-1:0]     stk_rdata;

	logic                 in_acc;
	logic                 clr_last;
	logic                 out_load;
	logic                 room;

	// Neighbour that the scan looks at in this cycle.
	logic [COORD_W-1:0]   nb_row, nb_col;
	logic                 nb_exist;

	// Choice of the next tile.
	logic [2:0]           cnt;
	logic [1:0]           sel;
	logic [1:0]           pick_dir;
	logic [COORD_W-1:0]   nxt_row, nxt_col;
	logic [WALL_W-1:0]    nxt_wall;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign clr_last  = (clr_q == ADDR_W'(TILES - 1));
	assign room      = !out_valid_q || m_axis_tready;
	assign out_load  = (state_q == ST_FIN) && room;
	assign stk_raddr = ADDR_W'(depth_q - 1'b1);

	// The scan visits down, right, left and up in that order, one per cycle. Positions
	// outside the grid are still read, but their answer is masked off by the exist bit.
	always_comb begin
		nb_row   = row_q;
		nb_col   = col_q;
		nb_exist = 1'b0;
		unique case (dir_t'(k_q[1:0]))
			DIR_DOWN: begin
				nb_row   = row_q + 1'b1;
				nb_exist = (row_q != COORD_W'(SIDE - 1));
			end
			DIR_RIGHT: begin
				nb_col   = col_q + 1'b1;
				nb_exist = (col_q != COORD_W'(SIDE - 1));
			end
			DIR_LEFT: begin
				nb_col   = col_q - 1'b1;
				nb_exist = (col_q != '0);
			end
			DIR_UP: begin
				nb_row   = row_q - 1'b1;
				nb_exist = (row_q != '0);
			end
		endcase
	end

	// Count the candidates, reduce the random value by the count and walk to the selected
	// candidate in listing order.
	always_comb begin
		logic [1:0] seen;
		cnt = 3'(cand_q[0]) + 3'(cand_q[1]) + 3'(cand_q[2]) + 3'(cand_q[3]);
		unique case (cnt)
			3'd3:    sel = mod3(rnd_q);
			3'd4:    sel = rnd_q[1:0];
			3'd2:    sel = {1'b0, rnd_q[0]};
			default: sel = 2'd0;
		endcase
		pick_dir = 2'd0;
		seen     = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (cand_q[i]) begin
				pick_dir = 2'(i);
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (cand_q[i]) begin
				if (seen == sel) begin
					pick_dir = 2'(i);
				end
				seen = seen + 1'b1;
			end
		end
	end

	// Target position and the wall it shares with the current tile.
	always_comb begin
		nxt_row  = row_q;
		nxt_col  = col_q;
		nxt_wall = '0;
		unique case (dir_t'(pick_dir))
			DIR_DOWN: begin
				nxt_row  = row_q + 1'b1;
				nxt_wall = WALL_W'(tile_of(row_q, col_q)) + WALL_W'(SIDE);
			end
			DIR_RIGHT: begin
				nxt_col  = col_q + 1'b1;
				nxt_wall = vwall_of(row_q, col_q) + 1'b1;
			end
			DIR_LEFT: begin
				nxt_col  = col_q - 1'b1;
				nxt_wall = vwall_of(row_q, col_q);
			end
			DIR_UP: begin
				nxt_row  = row_q - 1'b1;
				nxt_wall = WALL_W'(tile_of(row_q, col_q));
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		vis_we        = 1'b0;
		vis_waddr     = clr_q;
		vis_wdata     = 1'b0;
		vis_raddr     = tile_of(nb_row, nb_col);
		stk_we        = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				// Tile zero is the start of the maze and is visited from the outset.
				vis_we    = 1'b1;
				vis_wdata = (clr_q == '0);
				if (clr_last) begin
					state_d = restart_pend_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == CMD_RESTART) begin
						state_d = ST_CLEAR;
					end else if (done_q) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (k_q == 3'd4) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (cnt != '0) begin
					vis_we    = 1'b1;
					vis_waddr = tile_of(nxt_row, nxt_col);
					vis_wdata = 1'b1;
					stk_we    = (depth_q < DEPTH_W'(TILES));
					state_d   = ST_FIN;
				end else if (depth_q != '0) begin
					// The stack RAM read of the top entry is issued in this cycle.
					state_d = ST_POP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_POP: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (room) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Architectural state and sequencing counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			restart_pend_q <= 1'b0;
			row_q          <= '0;
			col_q          <= '0;
			depth_q        <= '0;
			done_q         <= 1'b0;
			k_q            <= '0;
			scan_pend_s1   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			scan_pend_s1 <= (state_q == ST_SCAN) && (k_q != 3'd4);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						restart_pend_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					k_q <= '0;
					if (in_acc && s_axis_tuser == CMD_RESTART) begin
						row_q          <= '0;
						col_q          <= '0;
						depth_q        <= '0;
						done_q         <= 1'b0;
						restart_pend_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (k_q != 3'd4) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (cnt != '0) begin
						row_q <= nxt_row;
						col_q <= nxt_col;
						if (depth_q < DEPTH_W'(TILES)) begin
							depth_q <= depth_q + 1'b1;
						end
					end else if (depth_q != '0) begin
						depth_q <= depth_q - 1'b1;
					end else begin
						done_q <= 1'b1;
					end
				end
				ST_POP: begin
					{row_q, col_q} <= stk_rdata;
				end
				ST_FIN: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Request payload, candidate flags and the pending result.
	always_ff @(posedge clk) begin
		dir_s1   <= k_q[1:0];
		exist_s1 <= nb_exist;
		if (scan_pend_s1) begin
			cand_q[dir_s1] <= exist_s1 && !vis_rdata;
		end
		if (in_acc) begin
			rnd_q        <= s_axis_tdata[RND_W-1:0];
			cand_q       <= '0;
			res_carved_q <= 1'b0;
			res_wall_q   <= '0;
			res_back_q   <= 1'b0;
		end
		if (state_q == ST_PICK && cnt != '0) begin
			res_carved_q <= 1'b1;
			res_wall_q   <= nxt_wall;
		end
		if (state_q == ST_POP) begin
			res_back_q <= 1'b1;
		end
		if (out_load) begin
			out_q.tile_now    <= TILE_W'(tile_of(row_q, col_q));
			out_q.carved      <= res_carved_q;
			out_q.wall_index  <= res_wall_q;
			out_q.backtracked <= res_back_q;
			out_q.done_res    <= done_q;
		end
	end

	gmd_ram #(
		.WIDTH(1),
		.DEPTH(TILES)
	) u_visited (
		.clk  (clk),
		.we   (vis_we),
		.waddr(vis_waddr),
		.wdata(vis_wdata),
		.raddr(vis_raddr),
		.rdata(vis_rdata)
	);

	// The tile being left is pushed as its row and column.
	gmd_ram #(
		.WIDTH(STK_W),
		.DEPTH(TILES)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(depth_q[ADDR_W-1:0]),
		.wdata({row_q, col_q}),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_DATA_W'(out_q);

	// The stack never holds more entries than there are tiles.
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(TILES))
		else $error("path stack depth beyond the tile count");

	// A push only happens while the stack has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (depth_q < DEPTH_W'(TILES)))
		else $error("push onto a full path stack");

	// One result never reports both a carve and a backtrack.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.carved && out_q.backtracked))
		else $error("carve and backtrack in one result");

	// A finished maze reports no movement.
	a_done_still: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |-> (!out_q.carved && !out_q.backtracked))
		else $error("movement reported with done");

	// Without a carve the wall field is zero.
	a_wall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.carved) |-> (out_q.wall_index == '0))
		else $error("wall index set without a carve");

	// Requests are only taken once the visited map has been swept.
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("request taken during the visited map sweep");

endmodule

@@ tb/grid_maze_dfs_checker.sv @@
`timescale 1ns / 1ps
module grid_maze_dfs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	// random_value [7:0]
	input  logic [gmd_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// command [0]
	input  logic                          s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tile_now [9:0], carved [10], wall_index [22:11], backtracked [23], done_res [24]
	input  logic [gmd_pkg::M_DATA_W-1:0]  m_axis_tdata,
	output int unsigned                   mismatch_count,
	output int unsigned                   results_due,
	output int unsigned                   carve_count,
	output int unsigned                   backtrack_count,
	output int unsigned                   done_count
);
	import gmd_pkg::*;

	// Shadow copy of the carver state.
	logic              visited [TILES];
	logic [TILE_W-1:0] trail [TILES];
	int unsigned       trail_len;
	int unsigned       here;
	logic              finished;
	result_t           expected_q [$];

	function automatic void clear_maze();
		for (int i = 0; i < TILES; i++) begin
			visited[i] = 1'b0;
		end
		visited[0] = 1'b1;
		trail_len = 0;
		here = 0;
		finished = 1'b0;
	endfunction

	function automatic result_t advance_maze(input logic cmd, input logic [RND_W-1:0] rnd);
		result_t     r;
		int unsigned options [4];
		int unsigned n;
		int unsigned t;
		int unsigned row;
		int unsigned col;
		int unsigned pick;
		int unsigned left_wall;
		r = '0;
		if (cmd == CMD_RESTART) begin
			clear_maze();
		end else if (!finished) begin
			t = here;
			row = t / SIDE;
			col = t % SIDE;
			n = 0;
			// Candidates are listed down, right, left, up.
			if (row + 1 < SIDE && !visited[t + SIDE]) begin
				options[n] = t + SIDE;
				n++;
			end
			if (col + 1 < SIDE && !visited[t + 1]) begin
				options[n] = t + 1;
				n++;
			end
			if (col > 0 && !visited[t - 1]) begin
				options[n] = t - 1;
				n++;
			end
			if (row > 0 && !visited[t - SIDE]) begin
				options[n] = t - SIDE;
				n++;
			end
			if (n != 0) begin
				pick = options[int'(rnd) % n];
				left_wall = VWALL_BASE + row * (SIDE + 1) + col;
				if (pick == t + SIDE) begin
					r.wall_index = WALL_W'(pick);
				end else if (pick == t + 1) begin
					r.wall_index = WALL_W'(left_wall + 1);
				end else if (pick + 1 == t) begin
					r.wall_index = WALL_W'(left_wall);
				end else begin
					r.wall_index = WALL_W'(t);
				end
				r.carved = 1'b1;
				visited[pick] = 1'b1;
				trail[trail_len] = TILE_W'(t);
				trail_len++;
				here = pick;
			end else if (trail_len > 0) begin
				trail_len--;
				here = trail[trail_len];
				r.backtracked = 1'b1;
			end else begin
				finished = 1'b1;
			end
		end
		r.tile_now = TILE_W'(here);
		r.done_res = finished;
		return r;
	endfunction

	function automatic void compare_field(input string label, input logic [WALL_W-1:0] want,
			input logic [WALL_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			clear_maze();
			expected_q.delete();
			mismatch_count = 0;
			results_due = 0;
			carve_count = 0;
			backtrack_count = 0;
			done_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[RES_W-1:0]);
				if (expected_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: result expected none, got tile_now %0d carved %0d wall %0d",
						$time, got.tile_now, got.carved, got.wall_index);
				end else begin
					want = expected_q.pop_front();
					compare_field("tile_now", WALL_W'(want.tile_now), WALL_W'(got.tile_now));
					compare_field("carved", WALL_W'(want.carved), WALL_W'(got.carved));
					compare_field("wall_index", want.wall_index, got.wall_index);
					compare_field("backtracked", WALL_W'(want.backtracked),
						WALL_W'(got.backtracked));
					compare_field("done_res", WALL_W'(want.done_res), WALL_W'(got.done_res));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = advance_maze(s_axis_tuser, s_axis_tdata[RND_W-1:0]);
				carve_count += want.carved;
				backtrack_count += want.backtracked;
				done_count += want.done_res;
				expected_q.push_back(want);
			end
			results_due = expected_q.size();
		end
	end

endmodule

@@ tb/tb_grid_maze_dfs_step_unit.sv @@
`timescale 1ns / 1ps
module tb_grid_maze_dfs_step_unit;
	import gmd_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 10;
	// A restart sweeps the whole visited map before the block talks again; the limit
	// allows several times the length of that sweep.
	localparam int STALL_LIMIT  = 8 * TILES;
	// Length of the deliberate receiver hold-off, long enough to fill the block.
	localparam int HOLD_CYCLES  = 300;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// random_value [7:0]
	logic [S_DATA_W-1:0] s_axis_tdata;
	// command [0]
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// tile_now [9:0], carved [10], wall_index [22:11], backtracked [23], done_res [24]
	logic [M_DATA_W-1:0] m_axis_tdata;

	int unsigned mismatch_count;
	int unsigned results_due;
	int unsigned carve_count;
	int unsigned backtrack_count;
	int unsigned done_count;

	// Percentages of cycles in which each side holds back, changed between phases.
	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	// Set by the stimulus to ask the receiver for one long hold-off; cleared when it is over.
	bit          hold_receiver;
	int unsigned stall_cycles;
	int unsigned requests_sent;
	int unsigned restarts_sent;

	grid_maze_dfs_step_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	grid_maze_dfs_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.mismatch_count  (mismatch_count),
		.results_due     (results_due),
		.carve_count     (carve_count),
		.backtrack_count (backtrack_count),
		.done_count      (done_count)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// The receiver decides afresh at every falling edge whether it will take a result.
	// A hold-off request keeps it closed for a long stretch, counted here, so that the
	// result register fills and the block has to refuse further requests.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_receiver) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_receiver = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// The watchdog counts cycles in which neither stream moves anything.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Watchdog: no transfer for %0d cycles.", STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Offers one request and returns at the falling edge after it has been taken. The
	// valid line is left high, so that a following request without a gap keeps it high;
	// each falling edge assigns it at most once.
	task automatic send_request(input logic cmd, input logic [RND_W-1:0] rnd);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_DATA_W'(rnd);
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
		requests_sent++;
		if (cmd == CMD_RESTART) begin
			restarts_sent++;
		end
	endtask

	// Mostly steps with random choices; now and then a restart. Restarts are kept
	// rare because each one sweeps the whole visited map.
	task automatic random_requests(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(79) == 0) begin
				send_request(CMD_RESTART, RND_W'($urandom_range(255)));
			end else begin
				send_request(CMD_STEP, RND_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		s_axis_tvalid     = 1'b0;
		s_axis_tdata      = '0;
		s_axis_tuser      = CMD_STEP;
		arst_n            = 1'b0;
		hold_receiver     = 1'b0;
		requests_sent     = 0;
		restarts_sent     = 0;
		sender_idle_pct   = 25;
		receiver_idle_pct = 57;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed opening. From tile zero the walk goes down, right, right, up into the
		// top row and left into tile one, whose neighbours are then all visited, so the
		// next step must backtrack. In the top row the tile above is kept out of the list.
		send_request(CMD_STEP, 8'h00);
		send_request(CMD_STEP, 8'h01);
		send_request(CMD_STEP, 8'h01);
		send_request(CMD_STEP, 8'h02);
		send_request(CMD_STEP, 8'h01);
		send_request(CMD_STEP, 8'hFF);
		send_request(CMD_STEP, 8'h00);
		// A restart straight after another, both with extreme random values.
		send_request(CMD_RESTART, 8'hFF);
		send_request(CMD_RESTART, 8'h00);
		// Odd choices run right along the top row; the rest spread the random bits.
		send_request(CMD_STEP, 8'h01);
		send_request(CMD_STEP, 8'h81);
		send_request(CMD_STEP, 8'hFF);
		send_request(CMD_STEP, 8'h80);
		send_request(CMD_STEP, 8'h7F);
		send_request(CMD_STEP, 8'h55);
		send_request(CMD_STEP, 8'hAA);
		send_request(CMD_STEP, 8'hFE);
		send_request(CMD_STEP, 8'h03);
		random_requests(170);

		// Second phase: the roles of the two sides are swapped, and the walk then starts
		// afresh from tile zero.
		sender_idle_pct   = 57;
		receiver_idle_pct = 25;
		random_requests(170);
		send_request(CMD_RESTART, RND_W'($urandom_range(255)));

		// Third phase: neither side idles. The sender first waits until every result is
		// back, then the receiver closes for a long stretch while requests keep coming.
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		s_axis_tvalid <= 1'b0;
		wait (results_due == 0);
		@(negedge clk);
		hold_receiver = 1'b1;
		random_requests(160);

		s_axis_tvalid <= 1'b0;
		wait (results_due == 0);
		repeat (20) @(negedge clk);

		$display("Sent %0d requests, %0d of them restarts, under three idling patterns.",
			requests_sent, restarts_sent);
		$display("Results seen: %0d carves, %0d backtracks, %0d with done set; %0d mismatches.",
			carve_count, backtrack_count, done_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/gmd_pkg.sv
sv/gmd_ram.sv
sv/grid_maze_dfs_step_unit.sv
tb/grid_maze_dfs_checker.sv
tb/tb_grid_maze_dfs_step_unit.sv
